### sv/lobm_pkg.sv
// Shared types and constants of the limit order book matcher.
// Depends on nothing; every other file imports it.
package lobm_pkg;

    localparam int BOOK_DEPTH = 16;
    localparam int DEPTH_W    = $clog2(BOOK_DEPTH);
    localparam int AVAIL_W    = 31 + $clog2(BOOK_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_CANCEL = 2'd1,
        CMD_MODIFY = 2'd2,
        CMD_NONE   = 2'd3
    } command_t;

    typedef enum logic [2:0] {
        KIND_TRADE   = 3'd0,
        KIND_REDUCED = 3'd1,
        KIND_REMOVED = 3'd2,
        KIND_RESTED  = 3'd3,
        KIND_QUOTE   = 3'd4,
        KIND_ERROR   = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_ZERO_ID   = 3'd1,
        ERR_ID_ORDER  = 3'd2,
        ERR_ZERO_QTY  = 3'd3,
        ERR_NOT_FOUND = 3'd4,
        ERR_FULL      = 3'd5
    } err_t;

    typedef enum logic [1:0] {
        QS_BOTH   = 2'd0,
        QS_NO_BID = 2'd1,
        QS_NO_ASK = 2'd2
    } quote_status_t;

    typedef struct packed {
        command_t    command;
        logic        side;
        logic [30:0] ord_id;
        logic [30:0] quantity;
        logic [30:0] price;
    } order_t;

    typedef struct packed {
        kind_t         kind;
        logic [30:0]   ref_id;
        logic          ref_side;
        logic [30:0]   amount;
        logic [30:0]   at_price;
        err_t          error_code;
        quote_status_t quote_status;
        logic [31:0]   mid_twice;
        logic          last;
    } result_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN_INIT,
        S_SCAN,
        S_DECIDE,
        S_TRADE,
        S_UPDATE,
        S_INSERT,
        S_ERROR
    } state_t;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_FILL,
        PH_QUOTE
    } phase_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SCAN_START,
        OP_SCAN_STEP,
        OP_MARK_ADD,
        OP_EMIT_TRADE,
        OP_APPLY_FILL,
        OP_INSERT,
        OP_APPLY_CM,
        OP_EMIT_QUOTE,
        OP_EMIT_ERR
    } op_t;

    typedef struct packed {
        op_t  op;
        err_t err;
    } dp_cmd_t;

    typedef struct packed {
        err_t pre_err;
        logic is_add;
        logic is_none;
        logic scan_last;
        logic book_full;
        logic cross_ok;
        logic qty_left;
        logic hit_found;
        logic filled;
        logic out_free;
    } dp_stat_t;

endpackage

### sv/lobm_ord_if.sv
// Order input channel: valid/ready handshake with one order payload.
// Depends on lobm_pkg.
interface lobm_ord_if
    import lobm_pkg::*;
();
    logic   valid;
    logic   ready;
    order_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/lobm_res_if.sv
// Result output channel: valid/ready handshake with one result payload.
// Depends on lobm_pkg.
interface lobm_res_if
    import lobm_pkg::*;
();
    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/lobm_dp.sv
// Datapath: bid and ask tables, sequential table scan, order registers
// and the result output register. Depends on lobm_pkg.
module lobm_dp
    import lobm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  dp_cmd_t  cmd,
    input  order_t   in_data,
    input  logic     out_ready,
    output dp_stat_t stat,
    output logic     out_valid,
    output result_t  out_data
);

    // tables: index 0 bids, 1 asks
    logic        valid_reg [2][BOOK_DEPTH];
    logic [30:0] id_tab    [2][BOOK_DEPTH];
    logic [30:0] qty_tab   [2][BOOK_DEPTH];
    logic [30:0] price_tab [2][BOOK_DEPTH];

    command_t    cmd_reg;
    logic        side_reg;
    logic [30:0] id_reg;
    logic [30:0] qty_reg, qty_next;
    logic [30:0] price_reg;
    logic [30:0] hi_id_reg;
    logic        filled_reg;

    logic [DEPTH_W-1:0] idx_reg;
    logic               bb_found_reg, ba_found_reg;
    logic [30:0]        bb_id_reg, bb_qty_reg, bb_price_reg;
    logic [30:0]        ba_id_reg, ba_qty_reg, ba_price_reg;
    logic [DEPTH_W-1:0] bb_idx_reg, ba_idx_reg;
    logic [AVAIL_W-1:0] avail_reg;
    logic               free_found_reg, hit_found_reg;
    logic [DEPTH_W-1:0] free_idx_reg, hit_idx_reg;

    logic        out_valid_reg;
    result_t     out_reg, res_next;
    logic        emit;

    logic        opp;
    logic        ob_found;
    logic [30:0] ob_id, ob_qty, ob_price;
    logic [DEPTH_W-1:0] ob_idx;
    logic        ob_cross;
    logic        ob_reduce;
    logic [30:0] ob_left;

    // scanned entry of both tables
    logic        e_val  [2];
    logic [30:0] e_id   [2];
    logic [30:0] e_qty  [2];
    logic [30:0] e_pr   [2];
    logic        bid_better, ask_better, opp_cross, own_hit;

    assign opp      = ~side_reg;
    assign ob_found = side_reg ? bb_found_reg : ba_found_reg;
    assign ob_id    = side_reg ? bb_id_reg    : ba_id_reg;
    assign ob_qty   = side_reg ? bb_qty_reg   : ba_qty_reg;
    assign ob_price = side_reg ? bb_price_reg : ba_price_reg;
    assign ob_idx   = side_reg ? bb_idx_reg   : ba_idx_reg;
    assign ob_cross = side_reg ? (price_reg <= ob_price) : (price_reg >= ob_price);
    assign ob_reduce = ob_qty > qty_reg;
    assign ob_left   = ob_qty - qty_reg;

    always_comb
    begin
        for (int s = 0; s < 2; s++)
        begin
            e_val[s] = valid_reg[s][idx_reg];
            e_id[s]  = id_tab[s][idx_reg];
            e_qty[s] = qty_tab[s][idx_reg];
            e_pr[s]  = price_tab[s][idx_reg];
        end
        bid_better = e_val[0] && (!bb_found_reg || e_pr[0] > bb_price_reg ||
                     (e_pr[0] == bb_price_reg && e_id[0] < bb_id_reg));
        ask_better = e_val[1] && (!ba_found_reg || e_pr[1] < ba_price_reg ||
                     (e_pr[1] == ba_price_reg && e_id[1] < ba_id_reg));
        opp_cross  = e_val[opp] &&
                     (opp ? (price_reg >= e_pr[opp]) : (price_reg <= e_pr[opp]));
        own_hit    = e_val[side_reg] && e_id[side_reg] == id_reg &&
                     e_pr[side_reg] == price_reg &&
                     (cmd_reg == CMD_MODIFY || e_qty[side_reg] == qty_reg);
    end

    // status to the controller
    always_comb
    begin
        stat.pre_err = ERR_NONE;
        if (id_reg == '0)
            stat.pre_err = ERR_ZERO_ID;
        else if (cmd_reg == CMD_ADD && id_reg <= hi_id_reg)
            stat.pre_err = ERR_ID_ORDER;
        else if (qty_reg == '0)
            stat.pre_err = ERR_ZERO_QTY;
        stat.is_add    = cmd_reg == CMD_ADD;
        stat.is_none   = cmd_reg == CMD_NONE;
        stat.scan_last = idx_reg == DEPTH_W'(BOOK_DEPTH - 1);
        stat.book_full = (avail_reg < {{(AVAIL_W-31){1'b0}}, qty_reg}) && !free_found_reg;
        stat.cross_ok  = ob_found && ob_cross && qty_reg != '0;
        stat.qty_left  = qty_reg != '0;
        stat.hit_found = hit_found_reg;
        stat.filled    = filled_reg;
        stat.out_free  = !out_valid_reg || out_ready;
    end

    // result to be registered
    always_comb
    begin
        res_next = '0;
        emit     = 1'b1;
        qty_next = qty_reg;
        case (cmd.op)
            OP_EMIT_TRADE:
            begin
                res_next.kind     = KIND_TRADE;
                res_next.ref_id   = ob_id;
                res_next.ref_side = opp;
                res_next.amount   = ob_reduce ? qty_reg : ob_qty;
                res_next.at_price = ob_price;
            end
            OP_APPLY_FILL:
            begin
                res_next.kind     = ob_reduce ? KIND_REDUCED : KIND_REMOVED;
                res_next.ref_id   = ob_id;
                res_next.ref_side = opp;
                res_next.amount   = ob_reduce ? ob_left : ob_qty;
                res_next.at_price = ob_price;
                qty_next          = ob_reduce ? '0 : qty_reg - ob_qty;
            end
            OP_INSERT:
            begin
                res_next.kind     = KIND_RESTED;
                res_next.ref_id   = id_reg;
                res_next.ref_side = side_reg;
                res_next.amount   = qty_reg;
                res_next.at_price = price_reg;
                emit              = filled_reg;
            end
            OP_EMIT_QUOTE:
            begin
                res_next.kind = KIND_QUOTE;
                res_next.last = 1'b1;
                if (!bb_found_reg)
                    res_next.quote_status = QS_NO_BID;
                else if (!ba_found_reg)
                    res_next.quote_status = QS_NO_ASK;
                else
                    res_next.mid_twice = {1'b0, bb_price_reg} + {1'b0, ba_price_reg};
            end
            OP_EMIT_ERR:
            begin
                res_next.kind       = KIND_ERROR;
                res_next.ref_id     = id_reg;
                res_next.ref_side   = side_reg;
                res_next.error_code = cmd.err;
                res_next.last       = 1'b1;
            end
            default:
                emit = 1'b0;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < 2; s++)
                for (int i = 0; i < BOOK_DEPTH; i++)
                    valid_reg[s][i] <= 1'b0;
            hi_id_reg     <= '0;
            filled_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            case (cmd.op)
                OP_MARK_ADD:
                begin
                    hi_id_reg  <= id_reg;
                    filled_reg <= 1'b0;
                end
                OP_APPLY_FILL:
                begin
                    filled_reg <= 1'b1;
                    if (!ob_reduce)
                        valid_reg[opp][ob_idx] <= 1'b0;
                end
                OP_INSERT:
                    valid_reg[side_reg][free_idx_reg] <= 1'b1;
                OP_APPLY_CM:
                    if (cmd_reg == CMD_CANCEL)
                        valid_reg[side_reg][hit_idx_reg] <= 1'b0;
                default:
                    ;
            endcase
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (emit)
            out_reg <= res_next;
        case (cmd.op)
            OP_LOAD:
            begin
                cmd_reg   <= in_data.command;
                side_reg  <= in_data.side;
                id_reg    <= in_data.ord_id;
                qty_reg   <= in_data.quantity;
                price_reg <= in_data.price;
            end
            OP_SCAN_START:
            begin
                idx_reg        <= '0;
                bb_found_reg   <= 1'b0;
                ba_found_reg   <= 1'b0;
                avail_reg      <= '0;
                free_found_reg <= 1'b0;
                hit_found_reg  <= 1'b0;
            end
            OP_SCAN_STEP:
            begin
                idx_reg <= idx_reg + 1'b1;
                if (bid_better)
                begin
                    bb_found_reg <= 1'b1;
                    bb_id_reg    <= e_id[0];
                    bb_qty_reg   <= e_qty[0];
                    bb_price_reg <= e_pr[0];
                    bb_idx_reg   <= idx_reg;
                end
                if (ask_better)
                begin
                    ba_found_reg <= 1'b1;
                    ba_id_reg    <= e_id[1];
                    ba_qty_reg   <= e_qty[1];
                    ba_price_reg <= e_pr[1];
                    ba_idx_reg   <= idx_reg;
                end
                if (opp_cross)
                    avail_reg <= avail_reg + {{(AVAIL_W-31){1'b0}}, e_qty[opp]};
                if (!e_val[side_reg] && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= idx_reg;
                end
                if (own_hit && !hit_found_reg)
                begin
                    hit_found_reg <= 1'b1;
                    hit_idx_reg   <= idx_reg;
                end
            end
            OP_APPLY_FILL:
            begin
                qty_reg <= qty_next;
                if (ob_reduce)
                    qty_tab[opp][ob_idx] <= ob_left;
            end
            OP_INSERT:
            begin
                id_tab[side_reg][free_idx_reg]    <= id_reg;
                qty_tab[side_reg][free_idx_reg]   <= qty_reg;
                price_tab[side_reg][free_idx_reg] <= price_reg;
            end
            OP_APPLY_CM:
                if (cmd_reg == CMD_MODIFY)
                    qty_tab[side_reg][hit_idx_reg] <= qty_reg;
            default:
                ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

### sv/lobm_ctrl.sv
// Controller state machine: sequences table scans, fills, insertion
// and result emission. Depends on lobm_pkg.
module lobm_ctrl
    import lobm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  dp_stat_t stat,
    output logic     in_ready,
    output dp_cmd_t  cmd
);

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    err_t   err_reg, err_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_FIRST;
            err_reg   <= ERR_NONE;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            err_reg   <= err_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        err_next   = err_reg;
        in_ready   = 1'b0;
        cmd.op     = OP_NONE;
        cmd.err    = err_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                phase_next = PH_FIRST;
                if (stat.is_none)
                    state_next = S_IDLE;
                else if (stat.pre_err != ERR_NONE)
                begin
                    err_next   = stat.pre_err;
                    state_next = S_ERROR;
                end
                else
                    state_next = S_SCAN_INIT;
            end
            S_SCAN_INIT:
            begin
                cmd.op     = OP_SCAN_START;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.op = OP_SCAN_STEP;
                if (stat.scan_last)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                case (phase_reg)
                    PH_FIRST:
                        if (stat.is_add)
                        begin
                            if (stat.book_full)
                            begin
                                err_next   = ERR_FULL;
                                state_next = S_ERROR;
                            end
                            else
                            begin
                                cmd.op     = OP_MARK_ADD;
                                phase_next = PH_FILL;
                            end
                        end
                        else if (stat.hit_found)
                        begin
                            cmd.op     = OP_APPLY_CM;
                            phase_next = PH_QUOTE;
                            state_next = S_SCAN_INIT;
                        end
                        else
                        begin
                            err_next   = ERR_NOT_FOUND;
                            state_next = S_ERROR;
                        end
                    PH_FILL:
                        if (stat.cross_ok)
                            state_next = S_TRADE;
                        else if (stat.qty_left)
                            state_next = S_INSERT;
                        else
                        begin
                            phase_next = PH_QUOTE;
                            state_next = S_SCAN_INIT;
                        end
                    default:
                        if (stat.out_free)
                        begin
                            cmd.op     = OP_EMIT_QUOTE;
                            state_next = S_IDLE;
                        end
                endcase
            end
            S_TRADE:
                if (stat.out_free)
                begin
                    cmd.op     = OP_EMIT_TRADE;
                    state_next = S_UPDATE;
                end
            S_UPDATE:
                if (stat.out_free)
                begin
                    cmd.op     = OP_APPLY_FILL;
                    phase_next = PH_FILL;
                    state_next = S_SCAN_INIT;
                end
            S_INSERT:
                if (stat.out_free || !stat.filled)
                begin
                    cmd.op     = OP_INSERT;
                    phase_next = PH_QUOTE;
                    state_next = S_SCAN_INIT;
                end
            S_ERROR:
                if (stat.out_free)
                begin
                    cmd.op     = OP_EMIT_ERR;
                    state_next = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

### sv/limit_order_book_matcher.sv
// Limit order book matcher, price-time priority, BOOK_DEPTH entries a side.
// Each table scan walks one entry per cycle.
// An add takes one scan, one more per fill and one for the quote; cancel
// and modify take two scans; output stalls hold the order in work;
// one order is in work at a time.
// Reset (rst_n low, asynchronous) empties both tables and clears the id floor.
module limit_order_book_matcher
    import lobm_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    lobm_ord_if.sink   orders,
    lobm_res_if.source results
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    lobm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (orders.valid),
        .stat     (stat),
        .in_ready (orders.ready),
        .cmd      (cmd)
    );

    lobm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (orders.data),
        .out_ready (results.ready),
        .stat      (stat),
        .out_valid (results.valid),
        .out_data  (results.data)
    );

endmodule

### sv/lobm_checker.sv
// Port-level checks of the order book matcher, bound to the top level.
// Depends on lobm_pkg.
module lobm_checker
    import lobm_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    res_valid,
    input logic    res_ready,
    input result_t res_data
);

    // a stalled transfer holds its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result changed while stalled");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.kind == KIND_ERROR |-> res_data.last)
        else $error("error result not final");

    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.last |->
            (res_data.kind == KIND_QUOTE || res_data.kind == KIND_ERROR))
        else $error("final result is neither quote nor error");

    a_quote_mid: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.kind == KIND_QUOTE && res_data.quote_status != QS_BOTH
            |-> res_data.mid_twice == '0)
        else $error("midquote on one-sided book");

endmodule

bind limit_order_book_matcher lobm_checker u_lobm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (results.valid),
    .res_ready (results.ready),
    .res_data  (results.data)
);
